>>> rtl/sfr_pkg.sv
// Shared types and codes for the sync frame receiver.
// Depends on nothing; used by every module under rtl.
package sfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned EventW = 3;
  localparam int unsigned LimitW = 9;
  localparam int unsigned StatW  = 32;
  localparam int unsigned CfgIdxW = 3;

  // Result event codes
  typedef enum logic [EventW-1:0] {
    EV_NONE    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_GOOD    = 3'd3,
    EV_SUMERR  = 3'd4,
    EV_DIRERR  = 3'd5,
    EV_LENERR  = 3'd6
  } sfr_event_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SYNC0     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SYNC1     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SYNC2     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SYNC3     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DIRECTION = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LEN_LIMIT = 3'd5;

  typedef struct packed {
    logic [3:0][ByteW-1:0] sync_byte;
    logic [ByteW-1:0]      accepted_direction;
    logic [LimitW-1:0]     length_limit;
  } sfr_cfg_t;

  // Packed so that the first field sits in the highest bits
  typedef struct packed {
    logic [StatW-1:0] frames_lost;
    logic [StatW-1:0] frames_good;
    logic [StatW-1:0] headers_seen;
    logic [ByteW-1:0] frame_ident;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] data_byte;
    sfr_event_t       event_res;
  } sfr_result_t;

  localparam int unsigned ResultW = $bits(sfr_result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

>>> rtl/sfr_core.sv
// Sync matcher and frame parser: holds the framing state and forms one result per byte.
// Depends on sfr_pkg.
module sfr_core #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [sfr_pkg::ByteW-1:0] rx_byte,
  input  sfr_pkg::sfr_cfg_t        cfg,
  output sfr_pkg::sfr_result_t     result
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_ID   = 3'd2,
    PH_DIR  = 3'd3,
    PH_BODY = 3'd4
  } phase_t;

  phase_t                    phase, phase_next;
  logic [1:0]                match_stage, match_stage_next;
  logic [sfr_pkg::ByteW-1:0] payload_count, payload_count_next;
  logic [sfr_pkg::ByteW-1:0] length_held, length_held_next;
  logic [sfr_pkg::ByteW-1:0] ident_held, ident_held_next;
  logic [sfr_pkg::ByteW-1:0] direction_held, direction_held_next;
  logic [sfr_pkg::ByteW-1:0] running_sum, running_sum_next;
  logic [COUNTER_WIDTH-1:0]  header_counter, header_counter_next;
  logic [COUNTER_WIDTH-1:0]  good_counter, good_counter_next;
  logic [COUNTER_WIDTH-1:0]  lost_snapshot, lost_snapshot_next;
  sfr_pkg::sfr_event_t       ev;
  logic [sfr_pkg::ByteW-1:0] out_data, out_index;
  logic                      sync_hit;

  always_comb begin
    match_stage_next    = match_stage;
    phase_next          = phase;
    payload_count_next  = payload_count;
    length_held_next    = length_held;
    ident_held_next     = ident_held;
    direction_held_next = direction_held;
    running_sum_next    = running_sum;
    header_counter_next = header_counter;
    good_counter_next   = good_counter;
    lost_snapshot_next  = lost_snapshot;
    ev                  = sfr_pkg::EV_NONE;
    out_data            = '0;
    out_index           = '0;
    sync_hit            = 1'b0;

    // Sync matcher runs on every byte
    if (rx_byte == cfg.sync_byte[match_stage]) begin
      if (match_stage == 2'd3) begin
        sync_hit = 1'b1;
        match_stage_next = 2'd0;
      end else begin
        match_stage_next = match_stage + 2'd1;
      end
    end else if (match_stage != 2'd0 && rx_byte == cfg.sync_byte[0]) begin
      match_stage_next = 2'd1;
    end else begin
      match_stage_next = 2'd0;
    end

    if (sync_hit) begin
      // Restart framing, drop any partial frame silently
      phase_next          = PH_LEN;
      payload_count_next  = '0;
      header_counter_next = header_counter + 1'b1;
      ev                  = sfr_pkg::EV_HEADER;
    end else begin
      unique case (phase)
        PH_LEN: begin
          length_held_next = rx_byte;
          running_sum_next = rx_byte;
          phase_next       = PH_ID;
        end
        PH_ID: begin
          ident_held_next  = rx_byte;
          running_sum_next = running_sum + rx_byte;
          phase_next       = PH_DIR;
        end
        PH_DIR: begin
          direction_held_next = rx_byte;
          running_sum_next    = running_sum + rx_byte;
          payload_count_next  = '0;
          phase_next          = PH_BODY;
        end
        PH_BODY: begin
          if (payload_count < length_held) begin
            running_sum_next   = running_sum + rx_byte;
            payload_count_next = payload_count + 1'b1;
            ev                 = sfr_pkg::EV_PAYLOAD;
            out_data           = rx_byte;
            out_index          = payload_count;
          end else begin
            payload_count_next = '0;
            phase_next         = PH_IDLE;
            // Checksum first, then direction, then length
            if (rx_byte != running_sum) begin
              ev = sfr_pkg::EV_SUMERR;
            end else if (direction_held != cfg.accepted_direction) begin
              ev = sfr_pkg::EV_DIRERR;
            end else if ({1'b0, length_held} < cfg.length_limit) begin
              ev                 = sfr_pkg::EV_GOOD;
              good_counter_next  = good_counter + 1'b1;
              lost_snapshot_next = header_counter - (good_counter + 1'b1);
            end else begin
              ev = sfr_pkg::EV_LENERR;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    result.event_res    = ev;
    result.data_byte    = out_data;
    result.byte_index   = out_index;
    result.frame_length = length_held_next;
    result.frame_ident  = ident_held_next;
    result.headers_seen = sfr_pkg::StatW'(header_counter_next);
    result.frames_good  = sfr_pkg::StatW'(good_counter_next);
    result.frames_lost  = sfr_pkg::StatW'(lost_snapshot_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      match_stage    <= '0;
      payload_count  <= '0;
      length_held    <= '0;
      ident_held     <= '0;
      direction_held <= '0;
      running_sum    <= '0;
      header_counter <= '0;
      good_counter   <= '0;
      lost_snapshot  <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      match_stage    <= match_stage_next;
      payload_count  <= payload_count_next;
      length_held    <= length_held_next;
      ident_held     <= ident_held_next;
      direction_held <= direction_held_next;
      running_sum    <= running_sum_next;
      header_counter <= header_counter_next;
      good_counter   <= good_counter_next;
      lost_snapshot  <= lost_snapshot_next;
    end
  end

endmodule

>>> rtl/sfr_out_buf.sv
// Output register with a skid entry, so input ready never waits on output ready.
// Depends on sfr_pkg.
module sfr_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfr_pkg::sfr_result_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sfr_pkg::sfr_result_t out_data
);

  logic                 skid_valid;
  sfr_pkg::sfr_result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        if (in_valid) begin
          out_data <= in_data;
        end
      end
    end else if (in_valid && in_ready) begin
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

>>> rtl/sync_frame_receiver_unit.sv
// Top level of the sync frame receiver: configuration registers, parser and output buffer.
// Depends on sfr_pkg, sfr_core and sfr_out_buf.
//
//  channel  | group                        | width | item
//  ---------+------------------------------+-------+---------------------------------
//  input    | s_tvalid/s_tready/s_tdata    | 8     | one received link byte
//  result   | m_tvalid/m_tready/m_tdata    | 136   | event, payload byte and counters
//  config   | cfg_valid/cfg_ready/cfg_*    | 3+9   | register index and write data
//
// One item enters per clock while s_tready is high; each byte yields exactly one result,
// shown on the next cycle when the output register is free, otherwise once the held
// results are taken. The rate is set by the parser update (running checksum, match stage).
// rst is synchronous: framing goes idle, counters and registers return to defaults.
// A stall on m_tready is absorbed by one skid entry; s_tready drops only when it fills.
// Configuration writes are always taken; cfg_ready is tied high.
module sync_frame_receiver_unit #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // rx_byte [7:0]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sfr_pkg::ByteW-1:0]      s_tdata,
  // event_res [2:0], data_byte [10:3], byte_index [18:11], frame_length [26:19],
  // frame_ident [34:27], headers_seen [66:35], frames_good [98:67],
  // frames_lost [130:99], zero fill [135:131]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sfr_pkg::OutDataW-1:0]   m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfr_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [sfr_pkg::LimitW-1:0]     cfg_data
);

  sfr_pkg::sfr_cfg_t    cfg;
  sfr_pkg::sfr_result_t core_result;
  sfr_pkg::sfr_result_t out_result;
  logic                 in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte          <= '0;
      cfg.accepted_direction <= '0;
      cfg.length_limit       <= sfr_pkg::LimitW'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfr_pkg::REG_SYNC0:     cfg.sync_byte[0] <= cfg_data[sfr_pkg::ByteW-1:0];
        sfr_pkg::REG_SYNC1:     cfg.sync_byte[1] <= cfg_data[sfr_pkg::ByteW-1:0];
        sfr_pkg::REG_SYNC2:     cfg.sync_byte[2] <= cfg_data[sfr_pkg::ByteW-1:0];
        sfr_pkg::REG_SYNC3:     cfg.sync_byte[3] <= cfg_data[sfr_pkg::ByteW-1:0];
        sfr_pkg::REG_DIRECTION: cfg.accepted_direction <= cfg_data[sfr_pkg::ByteW-1:0];
        sfr_pkg::REG_LEN_LIMIT: cfg.length_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser: state advances only on an accepted item
  sfr_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .rx_byte(s_tdata),
    .cfg    (cfg),
    .result (core_result)
  );

  // Hold the result until taken; a second result waits in the skid entry
  sfr_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_accept),
    .in_ready (s_tready),
    .in_data  (core_result),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_result)
  );

  assign m_tdata = {(sfr_pkg::OutDataW - sfr_pkg::ResultW)'(0), out_result};

  // After an accepted item, a result is always valid on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_tvalid)
    else $error("accepted item produced no result");

  // Input is refused only while a result is held
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with output empty");

  // A payload index always lies inside the frame length
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_result.event_res == sfr_pkg::EV_PAYLOAD |->
      out_result.byte_index < out_result.frame_length)
    else $error("payload index beyond frame length");

endmodule
